>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the user data header parser
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/uhp_pkg.sv
// ----------------------------------------------------------------------------
// uhp_pkg
// types and constants of the user data header parser
// ----------------------------------------------------------------------------
package uhp_pkg;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_ID   = 2'd1,
    PH_ELEN = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_TRUNC    = 2'd2
  } status_t;

  localparam logic [7:0] CONCAT_ID  = 8'd0;
  localparam logic [7:0] CONCAT_LEN = 8'd3;

  // capture slot of the concatenation element, CAP_SKIP means not capturing
  localparam logic [1:0] CAP_REF   = 2'd0;
  localparam logic [1:0] CAP_TOTAL = 2'd1;
  localparam logic [1:0] CAP_PART  = 2'd2;
  localparam logic [1:0] CAP_SKIP  = 2'd3;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic       concat_found;
    logic [7:0] ref_number;
    logic [7:0] total_parts;
    logic [7:0] part_number;
    logic [1:0] status;
  } out_beat_t;

endpackage

>>> sv/uhp_stream_if.sv
// ----------------------------------------------------------------------------
// uhp_stream_if
// valid/ready stream channel carrying one payload struct per beat
// ----------------------------------------------------------------------------
interface uhp_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/uhp_in_reg.sv
// ----------------------------------------------------------------------------
// uhp_in_reg
// input register stage, holds one header byte until the parser takes it
// ----------------------------------------------------------------------------
module uhp_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  uhp_pkg::in_beat_t in_data,
  output logic             beat_valid,
  output uhp_pkg::in_beat_t beat_data,
  input  logic             beat_take
);

  logic              valid_r;
  logic              valid_nxt;
  uhp_pkg::in_beat_t data_r;

  assign in_ready  = !valid_r || beat_take;
  assign beat_valid = valid_r;
  assign beat_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (beat_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

>>> sv/uhp_parse_core.sv
// ----------------------------------------------------------------------------
// uhp_parse_core
// element phase machine, concatenation capture and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uhp_parse_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               beat_valid,
  input  uhp_pkg::in_beat_t  beat_data,
  output logic               beat_take,
  output logic               res_valid,
  input  logic               res_ready,
  output uhp_pkg::out_beat_t res_data
);

  uhp_pkg::phase_t    phase_r, phase_nxt;
  logic [7:0]         cnt_r, cnt_nxt;
  logic               over_r, over_nxt;
  logic [7:0]         decl_r, decl_nxt;
  logic [7:0]         elem_id_r, elem_id_nxt;
  logic [7:0]         rem_r, rem_nxt;
  logic [1:0]         cap_r, cap_nxt;
  logic [7:0]         pend_ref_r, pend_ref_nxt;
  logic [7:0]         pend_total_r, pend_total_nxt;
  logic [7:0]         found_ref_r, found_ref_nxt;
  logic [7:0]         found_total_r, found_total_nxt;
  logic [7:0]         found_part_r, found_part_nxt;
  logic               found_r, found_nxt;
  logic               out_valid_r, out_valid_nxt;
  uhp_pkg::out_beat_t out_data_r, out_data_nxt;
  uhp_pkg::status_t   status;
  logic [7:0]         b;
  logic               is_last;

  assign b       = beat_data.header_byte;
  assign is_last = beat_data.last_byte;

  // non-final bytes never need the result slot
  assign beat_take = beat_valid && (!is_last || !out_valid_r || res_ready);

  assign res_valid = out_valid_r;
  assign res_data  = out_data_r;

  // state update for the byte, before the end-of-header reset
  always_comb begin
    phase_nxt       = phase_r;
    cnt_nxt         = cnt_r;
    over_nxt        = over_r;
    decl_nxt        = decl_r;
    elem_id_nxt     = elem_id_r;
    rem_nxt         = rem_r;
    cap_nxt         = cap_r;
    pend_ref_nxt    = pend_ref_r;
    pend_total_nxt  = pend_total_r;
    found_ref_nxt   = found_ref_r;
    found_total_nxt = found_total_r;
    found_part_nxt  = found_part_r;
    found_nxt       = found_r;

    if (phase_r == uhp_pkg::PH_LEN) begin
      decl_nxt  = b;
      cnt_nxt   = 8'd0;
      over_nxt  = 1'b0;
      phase_nxt = uhp_pkg::PH_ID;
    end else begin
      if (cnt_r == 8'hff) begin
        over_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 8'd1;
      end
      case (phase_r)
        uhp_pkg::PH_ID: begin
          elem_id_nxt = b;
          phase_nxt   = uhp_pkg::PH_ELEN;
        end
        uhp_pkg::PH_ELEN: begin
          rem_nxt   = b;
          cap_nxt   = (elem_id_r == uhp_pkg::CONCAT_ID && b == uhp_pkg::CONCAT_LEN)
                      ? uhp_pkg::CAP_REF : uhp_pkg::CAP_SKIP;
          phase_nxt = (b == 8'd0) ? uhp_pkg::PH_ID : uhp_pkg::PH_DATA;
        end
        uhp_pkg::PH_DATA: begin
          case (cap_r)
            uhp_pkg::CAP_REF: begin
              pend_ref_nxt = b;
              cap_nxt      = uhp_pkg::CAP_TOTAL;
            end
            uhp_pkg::CAP_TOTAL: begin
              pend_total_nxt = b;
              cap_nxt        = uhp_pkg::CAP_PART;
            end
            uhp_pkg::CAP_PART: begin
              found_ref_nxt   = pend_ref_r;
              found_total_nxt = pend_total_r;
              found_part_nxt  = b;
              found_nxt       = 1'b1;
              cap_nxt         = uhp_pkg::CAP_SKIP;
            end
            default: begin
            end
          endcase
          rem_nxt = rem_r - 8'd1;
          if (rem_r == 8'd1) begin
            phase_nxt = uhp_pkg::PH_ID;
          end
        end
        default: begin
        end
      endcase
    end

    if (over_nxt || cnt_nxt != decl_nxt) begin
      status = uhp_pkg::ST_MISMATCH;
    end else if (phase_nxt == uhp_pkg::PH_ELEN || phase_nxt == uhp_pkg::PH_DATA) begin
      status = uhp_pkg::ST_TRUNC;
    end else begin
      status = uhp_pkg::ST_OK;
    end

    out_data_nxt.status = status;
    if (status == uhp_pkg::ST_OK && found_nxt) begin
      out_data_nxt.concat_found = 1'b1;
      out_data_nxt.ref_number   = found_ref_nxt;
      out_data_nxt.total_parts  = found_total_nxt;
      out_data_nxt.part_number  = found_part_nxt;
    end else begin
      out_data_nxt.concat_found = 1'b0;
      out_data_nxt.ref_number   = 8'd0;
      out_data_nxt.total_parts  = 8'd0;
      out_data_nxt.part_number  = 8'd0;
    end

    out_valid_nxt = out_valid_r;
    if (beat_take && is_last) begin
      out_valid_nxt = 1'b1;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (beat_take && is_last)) begin
      phase_r       <= uhp_pkg::PH_LEN;
      cnt_r         <= 8'd0;
      over_r        <= 1'b0;
      decl_r        <= 8'd0;
      elem_id_r     <= 8'd0;
      rem_r         <= 8'd0;
      cap_r         <= uhp_pkg::CAP_REF;
      pend_ref_r    <= 8'd0;
      pend_total_r  <= 8'd0;
      found_ref_r   <= 8'd0;
      found_total_r <= 8'd0;
      found_part_r  <= 8'd0;
      found_r       <= 1'b0;
    end else if (beat_take) begin
      phase_r       <= phase_nxt;
      cnt_r         <= cnt_nxt;
      over_r        <= over_nxt;
      decl_r        <= decl_nxt;
      elem_id_r     <= elem_id_nxt;
      rem_r         <= rem_nxt;
      cap_r         <= cap_nxt;
      pend_ref_r    <= pend_ref_nxt;
      pend_total_r  <= pend_total_nxt;
      found_ref_r   <= found_ref_nxt;
      found_total_r <= found_total_nxt;
      found_part_r  <= found_part_nxt;
      found_r       <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_take && is_last) begin
      out_data_r <= out_data_nxt;
    end
  end

  `ASSERT_NEXT(a_restart_after_last, clk, rst_n, beat_take && is_last,
    phase_r == uhp_pkg::PH_LEN && !found_r && !over_r)
  `ASSERT_IMPL(a_found_only_ok, clk, rst_n, out_valid_r && out_data_r.concat_found,
    out_data_r.status == uhp_pkg::ST_OK)
  `ASSERT_IMPL(a_error_zeroes, clk, rst_n,
    out_valid_r && out_data_r.status != uhp_pkg::ST_OK,
    out_data_r.ref_number == 8'd0 && out_data_r.total_parts == 8'd0 &&
    out_data_r.part_number == 8'd0)
  `ASSERT_IMPL(a_data_owed, clk, rst_n, phase_r == uhp_pkg::PH_DATA, rem_r != 8'd0)

endmodule

>>> sv/sms_user_header_parser_unit.sv
// ----------------------------------------------------------------------------
// sms_user_header_parser_unit
// SMS user data header parser, reports the concatenation element per header
// ----------------------------------------------------------------------------
// in_ch carries one header byte per beat with last_byte set on the final
// byte; the first byte of each header is its declared length. out_ch carries
// one beat per header, issued for the final byte: status, and the reference,
// total parts and part number of the last concatenation element when the
// status is ok.
// A byte is taken into an input register, then the element phase machine
// updates its state when it takes the byte from there; the result beat is
// registered when the final byte is taken. One byte per cycle is sustained
// unless a final byte waits for the result slot.
// After the final byte the parser returns to expecting a length byte, so the
// next header may follow in the next cycle.
// Reset clears the phase machine and both valid flags.
// When out_ch stalls, non-final bytes keep flowing; a final byte waits in the
// input register until the pending result beat is taken, and in_ch.ready
// then drops.
// ----------------------------------------------------------------------------
module sms_user_header_parser_unit (
  input logic        clk,
  input logic        rst_n,
  uhp_stream_if.sink   in_ch,
  uhp_stream_if.source out_ch
);

  logic               beat_valid;
  uhp_pkg::in_beat_t  beat_data;
  logic               beat_take;

  uhp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_data    (in_ch.data),
    .beat_valid (beat_valid),
    .beat_data  (beat_data),
    .beat_take  (beat_take)
  );

  uhp_parse_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (beat_valid),
    .beat_data  (beat_data),
    .beat_take  (beat_take),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready),
    .res_data   (out_ch.data)
  );

endmodule
